/* rtl/flrs_pkg.sv */
package flrs_pkg;

    localparam int LOAD_COUNT_DEF     = 5;
    localparam int SAMPLE_RATE_DEF    = 16000;

    localparam int COUNT_W            = 16;
    localparam int SW_W               = 5;
    localparam int FREQ_W             = 22;
    localparam int ROC_W              = 24;
    localparam int FTH_W              = 7;
    localparam int RTH_W              = 10;
    localparam int HOLD_W             = 16;
    localparam int Q8_SHIFT           = 8;

    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 16;

    localparam int S_DATA_W           = 24;
    localparam int M_DATA_W           = 64;

    localparam int QUEUE_DEPTH        = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROC_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd2;

    localparam logic [FTH_W-1:0]  FTH_RESET  = 7'd49;
    localparam logic [RTH_W-1:0]  RTH_RESET  = 10'd20;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd500;

    localparam logic [FREQ_W-1:0] FREQ_MAX        = 22'h3FFFFF;
    localparam logic [FREQ_W-1:0] PREV_FREQ_RESET = 22'd12800;
    localparam logic [ROC_W-1:0]  ROC_MAX_POS     = 24'h7FFFFF;
    localparam logic [ROC_W-1:0]  ROC_MIN_NEG     = 24'h800000;

    typedef struct packed {
        logic               is_tick;
        logic [COUNT_W-1:0] count;
        logic [SW_W-1:0]    switches;
        logic               maint;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FDIV,
        ST_MUL,
        ST_RSTART,
        ST_RDIV,
        ST_APPLY
    } state_t;

endpackage

/* rtl/flrs_front.sv */
module flrs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] period_count, [20:16] switches, [21] maintenance
    input  logic [flrs_pkg::S_DATA_W-1:0] s_tdata,
    // [0] opcode
    input  logic                          s_tuser,
    output logic                          push,
    output flrs_pkg::item_t               push_item,
    input  logic                          q_full
);
    import flrs_pkg::*;

    logic  hold_valid_reg;
    item_t hold_item_reg;
    item_t in_item;
    logic  take;

    always_comb
    begin
        in_item.is_tick  = s_tuser;
        in_item.count    = (s_tdata[COUNT_W-1:0] == '0) ? COUNT_W'(1) : s_tdata[COUNT_W-1:0];
        in_item.switches = s_tdata[COUNT_W+SW_W-1:COUNT_W];
        in_item.maint    = s_tdata[COUNT_W+SW_W];
    end

    assign push      = hold_valid_reg && !q_full;
    assign s_tready  = !hold_valid_reg || !q_full;
    assign take      = s_tvalid && s_tready;
    assign push_item = hold_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_item_reg <= in_item;
        end
    end

endmodule

/* rtl/flrs_fifo.sv */
module flrs_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  flrs_pkg::item_t push_item,
    output logic            q_full,
    input  logic            pop,
    output logic            q_valid,
    output flrs_pkg::item_t q_item
);
    import flrs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign q_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entries_reg[rd_ptr_reg];
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/flrs_div.sv */
module flrs_div #(
    parameter int DIVIDEND_W = 36
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [DIVIDEND_W-1:0]        dividend,
    input  logic [flrs_pkg::COUNT_W-1:0] divisor,
    output logic                         done,
    output logic [DIVIDEND_W-1:0]        quotient
);
    import flrs_pkg::*;

    // radix-4 restoring: two quotient bits per cycle
    localparam int STEPS = (DIVIDEND_W + 1) / 2;
    localparam int PW    = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [COUNT_W:0]   rem_reg;
    logic [PW-1:0]      quo_reg;
    logic [COUNT_W-1:0] divisor_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [COUNT_W:0]   rem_step;
    logic [PW-1:0]      quo_step;

    always_comb
    begin
        logic [COUNT_W:0] r;
        logic [COUNT_W:0] rs;
        logic [PW-1:0]    qv;
        logic             qbit;
        r  = rem_reg;
        qv = quo_reg;
        for (int k = 0; k < 2; k++)
        begin
            rs = {r[COUNT_W-1:0], qv[PW-1]};
            if (rs >= {1'b0, divisor_reg})
            begin
                r    = rs - {1'b0, divisor_reg};
                qbit = 1'b1;
            end
            else
            begin
                r    = rs;
                qbit = 1'b0;
            end
            qv = {qv[PW-2:0], qbit};
        end
        rem_step = r;
        quo_step = qv;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[DIVIDEND_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= PW'(dividend);
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
        end
    end

endmodule

/* rtl/flrs_back.sv */
module flrs_back #(
    parameter int LOAD_COUNT     = flrs_pkg::LOAD_COUNT_DEF,
    parameter int SAMPLE_RATE_HZ = flrs_pkg::SAMPLE_RATE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [flrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [flrs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            q_valid,
    input  flrs_pkg::item_t                 q_item,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [flrs_pkg::M_DATA_W-1:0]   m_tdata
);
    import flrs_pkg::*;

    localparam int SR_W  = $clog2(SAMPLE_RATE_HZ + 1);
    localparam int MAG_W = FREQ_W + SR_W;
    localparam int EXT_W = (LOAD_COUNT > SW_W) ? LOAD_COUNT : SW_W;
    localparam logic [MAG_W-1:0] FNUM = MAG_W'(SAMPLE_RATE_HZ * 256);
    localparam logic [MAG_W-1:0] SR_K = MAG_W'(SAMPLE_RATE_HZ);

    state_t state_reg, state_next;

    logic [FTH_W-1:0]      fth_reg;
    logic [RTH_W-1:0]      rth_reg;
    logic [HOLD_W-1:0]     hold_reg;

    item_t                 item_reg;
    logic [FREQ_W-1:0]     freq_reg;
    logic [MAG_W-1:0]      prod_reg;
    logic                  neg_reg;
    logic [ROC_W-1:0]      roc_reg;

    logic [FREQ_W-1:0]     prev_freq_reg, prev_freq_next;
    logic [ROC_W-1:0]      last_roc_reg, last_roc_next;
    logic                  stable_reg, stable_next;
    logic [LOAD_COUNT-1:0] cur_reg, cur_next;
    logic [LOAD_COUNT-1:0] shed_reg, shed_next;
    logic [LOAD_COUNT-1:0] unshed_reg, unshed_next;
    logic                  managing_reg, managing_next;
    logic                  trun_reg, trun_next;
    logic                  tdone_reg, tdone_next;
    logic [HOLD_W-1:0]     tleft_reg, tleft_next;

    logic                  out_valid_reg;
    logic [M_DATA_W-1:0]   out_data_reg;
    logic [M_DATA_W-1:0]   out_data_next;
    logic                  slot_free;

    logic                  div_start;
    logic [MAG_W-1:0]      div_dividend;
    logic [COUNT_W-1:0]    div_divisor;
    logic                  div_done;
    logic [MAG_W-1:0]      div_quot;

    logic                  load_freq;
    logic                  load_prod;
    logic                  load_roc;
    logic                  commit;

    logic [FREQ_W-1:0]     freq_sat;
    logic [ROC_W-1:0]      roc_sat;
    logic signed [FREQ_W:0] diff;
    logic [FREQ_W:0]       diff_abs;

    flrs_div #(
        .DIVIDEND_W (MAG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign slot_free = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // saturation of the divider result; difference of new and previous frequency
    always_comb
    begin
        freq_sat = (div_quot > MAG_W'(FREQ_MAX)) ? FREQ_MAX : div_quot[FREQ_W-1:0];
        if (!neg_reg)
        begin
            roc_sat = (div_quot > MAG_W'(ROC_MAX_POS)) ? ROC_MAX_POS : div_quot[ROC_W-1:0];
        end
        else
        begin
            roc_sat = (div_quot > MAG_W'(ROC_MIN_NEG)) ? ROC_MIN_NEG
                                                       : (~div_quot[ROC_W-1:0] + 1'b1);
        end
        diff     = $signed({1'b0, freq_reg}) - $signed({1'b0, prev_freq_reg});
        diff_abs = diff[FREQ_W] ? (~diff + 1'b1) : diff;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        q_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = FNUM;
        div_divisor  = q_item.count;
        load_freq    = 1'b0;
        load_prod    = 1'b0;
        load_roc     = 1'b0;
        commit       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.is_tick)
                    begin
                        state_next = ST_APPLY;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_FDIV;
                    end
                end
            end
            ST_FDIV:
            begin
                if (div_done)
                begin
                    load_freq  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                load_prod  = 1'b1;
                state_next = ST_RSTART;
            end
            ST_RSTART:
            begin
                div_start    = 1'b1;
                div_dividend = prod_reg;
                div_divisor  = item_reg.count;
                state_next   = ST_RDIV;
            end
            ST_RDIV:
            begin
                if (div_done)
                begin
                    load_roc   = 1'b1;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (slot_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // relay decisions for the item in hand
    always_comb
    begin
        logic [EXT_W-1:0]      sw_ext;
        logic [LOAD_COUNT-1:0] sw;
        logic [LOAD_COUNT-1:0] cand;
        logic [LOAD_COUNT-1:0] rev;
        logic [LOAD_COUNT-1:0] pick;
        logic [LOAD_COUNT-1:0] pick_r;
        logic [ROC_W-1:0]      roc_abs;
        logic [EXT_W-1:0]      shed_ext;
        logic [EXT_W-1:0]      pow_ext;

        sw_ext = EXT_W'(item_reg.switches);
        sw     = sw_ext[LOAD_COUNT-1:0];

        prev_freq_next = prev_freq_reg;
        last_roc_next  = last_roc_reg;
        stable_next    = stable_reg;
        cur_next       = cur_reg;
        shed_next      = shed_reg;
        unshed_next    = unshed_reg;
        managing_next  = managing_reg;
        trun_next      = trun_reg;
        tdone_next     = tdone_reg;
        tleft_next     = tleft_reg;

        roc_abs = roc_reg[ROC_W-1] ? (~roc_reg + 1'b1) : roc_reg;
        cand    = '0;
        rev     = '0;
        pick    = '0;
        pick_r  = '0;

        if (item_reg.is_tick)
        begin
            if (trun_reg)
            begin
                if (tleft_reg <= HOLD_W'(1))
                begin
                    tleft_next = '0;
                    trun_next  = 1'b0;
                    tdone_next = 1'b1;
                end
                else
                begin
                    tleft_next = tleft_reg - 1'b1;
                end
            end
        end
        else
        begin
            prev_freq_next = freq_reg;
            last_roc_next  = roc_reg;
            stable_next    = !((freq_reg < FREQ_W'({fth_reg, 8'b0})) ||
                               (roc_abs > ROC_W'({rth_reg, 8'b0})));
            if (managing_reg)
            begin
                cur_next    = cur_reg & sw;
                shed_next   = shed_reg & sw;
                unshed_next = unshed_reg & sw;
            end
            else
            begin
                cur_next    = sw;
                unshed_next = sw;
            end

            if ((cur_next != '0) && !item_reg.maint)
            begin
                if (!trun_reg && !stable_next && (unshed_next != '0))
                begin
                    tdone_next    = 1'b0;
                    trun_next     = 1'b1;
                    tleft_next    = hold_reg;
                    cand          = cur_next & ~shed_next;
                    pick          = cand & (~cand + LOAD_COUNT'(1));
                    shed_next     = shed_next | pick;
                    unshed_next   = unshed_next & ~pick;
                    managing_next = 1'b1;
                end
                else if (!trun_reg && tdone_reg && stable_next && (shed_next != '0))
                begin
                    tdone_next = 1'b0;
                    trun_next  = 1'b1;
                    tleft_next = hold_reg;
                    cand       = cur_next & shed_next;
                    for (int i = 0; i < LOAD_COUNT; i++)
                    begin
                        rev[i] = cand[LOAD_COUNT-1-i];
                    end
                    pick_r = rev & (~rev + LOAD_COUNT'(1));
                    for (int i = 0; i < LOAD_COUNT; i++)
                    begin
                        pick[i] = pick_r[LOAD_COUNT-1-i];
                    end
                    shed_next   = shed_next & ~pick;
                    unshed_next = unshed_next | pick;
                    if (shed_next == '0)
                    begin
                        managing_next = 1'b0;
                    end
                end
            end
            else
            begin
                tdone_next    = 1'b0;
                managing_next = 1'b0;
                shed_next     = '0;
                unshed_next   = '0;
            end
        end

        shed_ext      = EXT_W'(shed_next);
        pow_ext       = EXT_W'(shed_next ^ cur_next);
        out_data_next = M_DATA_W'({last_roc_next, prev_freq_next, pow_ext[SW_W-1:0],
                                   shed_ext[SW_W-1:0], stable_next});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fth_reg       <= FTH_RESET;
            rth_reg       <= RTH_RESET;
            hold_reg      <= HOLD_RESET;
            prev_freq_reg <= PREV_FREQ_RESET;
            last_roc_reg  <= '0;
            stable_reg    <= 1'b1;
            cur_reg       <= '0;
            shed_reg      <= '0;
            unshed_reg    <= '0;
            managing_reg  <= 1'b0;
            trun_reg      <= 1'b0;
            tdone_reg     <= 1'b0;
            tleft_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FREQ_THR: fth_reg  <= cfg_data[FTH_W-1:0];
                    CFG_ROC_THR:  rth_reg  <= cfg_data[RTH_W-1:0];
                    CFG_HOLD:     hold_reg <= cfg_data[HOLD_W-1:0];
                    default:      ;
                endcase
            end
            if (commit)
            begin
                prev_freq_reg <= prev_freq_next;
                last_roc_reg  <= last_roc_next;
                stable_reg    <= stable_next;
                cur_reg       <= cur_next;
                shed_reg      <= shed_next;
                unshed_reg    <= unshed_next;
                managing_reg  <= managing_next;
                trun_reg      <= trun_next;
                tdone_reg     <= tdone_next;
                tleft_reg     <= tleft_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (load_freq)
        begin
            freq_reg <= freq_sat;
        end
        if (load_prod)
        begin
            prod_reg <= MAG_W'(diff_abs[FREQ_W-1:0]) * SR_K;
            neg_reg  <= diff[FREQ_W];
        end
        if (load_roc)
        begin
            roc_reg <= roc_sat;
        end
        if (commit)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

/* rtl/frequency_relay_load_shedder.sv */
// Operation: a tick goes from the queue straight to the apply state; a sample takes two
//   passes through the shared radix-4 divider, W = 22 + bits of SAMPLE_RATE_HZ wide (W = 36 at
//   16 kHz), for frequency and then rate of change. The back end takes no new item until the
//   current one is committed; the front stage and queue buffer arrivals meanwhile.
// Reset: asynchronous, active low; empties the queue, restores the register
//   defaults, 50 Hz previous frequency, stable, no loads shed, timer idle.
module frequency_relay_load_shedder #(
    parameter int LOAD_COUNT     = flrs_pkg::LOAD_COUNT_DEF,
    parameter int SAMPLE_RATE_HZ = flrs_pkg::SAMPLE_RATE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [flrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [flrs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] period_count, [20:16] switches, [21] maintenance
    input  logic [flrs_pkg::S_DATA_W-1:0]   s_tdata,
    // [0] opcode
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] stable, [5:1] shed_loads, [10:6] powered_loads,
    // [32:11] frequency_q8, [56:33] roc_q8
    output logic [flrs_pkg::M_DATA_W-1:0]   m_tdata
);
    import flrs_pkg::*;

    logic  push;
    item_t push_item;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    item_t q_item;

    flrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    flrs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    flrs_back #(
        .LOAD_COUNT     (LOAD_COUNT),
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
